[hdl/stable_priority_event_queue_assert.svh]
// ----------------------------------------------------------------------------
// stable priority event queue assertion macros
// concurrent checks clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_EVENT_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// field widths, action and status codes, types between controller and datapath
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ACTION_W = 3;
    localparam int PRIO_W   = 8;
    localparam int TAG_W    = 16;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;
    localparam int NUM_W    = 9;

    localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_COUNT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET_ID = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic load;
        logic look;
        logic scan;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic is_remove;
    } t_stat;

endpackage

[hdl/spq_req_if.sv]
// ----------------------------------------------------------------------------
// spq_req_if
// request channel: valid, ready and the request fields
// ----------------------------------------------------------------------------
interface spq_req_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_W-1:0]    handler_tag;
    logic [ID_W-1:0]     target_id;

    modport source (output valid, action, prio, handler_tag, target_id, input ready);
    modport sink   (input valid, action, prio, handler_tag, target_id, output ready);
endinterface

[hdl/spq_rsp_if.sv]
// ----------------------------------------------------------------------------
// spq_rsp_if
// response channel: valid, ready and the response fields
// ----------------------------------------------------------------------------
interface spq_rsp_if;
    import spq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     assigned_id;
    logic [POS_W-1:0]    position;
    logic [NUM_W-1:0]    number;

    modport source (output valid, status, assigned_id, position, number, input ready);
    modport sink   (input valid, status, assigned_id, position, number, output ready);
endinterface

[hdl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer for load, compare, prefix scan and update of one request
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_cmd o_cmd,
    input  spq_pkg::t_stat i_stat
);
    import spq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_stat.is_remove ? S_SCAN : S_APPLY;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

[hdl/spq_dpath.sv]
// ----------------------------------------------------------------------------
// spq_dpath
// sorted entry row with per-entry compare, shift cells, id counter and result
// ----------------------------------------------------------------------------
module spq_dpath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spq_pkg::t_cmd                i_cmd,
    output spq_pkg::t_stat               o_stat,
    input  logic [spq_pkg::ACTION_W-1:0] i_action,
    input  logic [spq_pkg::PRIO_W-1:0]   i_prio,
    input  logic [spq_pkg::TAG_W-1:0]    i_handler_tag,
    input  logic [spq_pkg::ID_W-1:0]     i_target_id,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [spq_pkg::ID_W-1:0]     o_assigned_id,
    output logic [spq_pkg::POS_W-1:0]    o_position,
    output logic [spq_pkg::NUM_W-1:0]    o_number
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [PRIO_W-1:0]   r_ent_prio [CAPACITY];
    logic [ID_W-1:0]     r_ent_id   [CAPACITY];
    logic [TAG_W-1:0]    r_ent_tag  [CAPACITY];
    logic [PRIO_W-1:0]   n_ent_prio [CAPACITY];
    logic [ID_W-1:0]     n_ent_id   [CAPACITY];
    logic [TAG_W-1:0]    n_ent_tag  [CAPACITY];

    logic [CW-1:0]       r_count, n_count;
    logic [ID_W-1:0]     r_next_id, n_next_id;

    logic [ACTION_W-1:0] r_action;
    logic [PRIO_W-1:0]   r_prio;
    logic [TAG_W-1:0]    r_tag;
    logic [ID_W-1:0]     r_target;

    logic [CAPACITY-1:0] r_ge, n_ge;
    logic [CAPACITY-1:0] r_match, n_match;
    logic [CAPACITY-1:0] r_pre, n_pre;
    logic [CAPACITY-1:0] ge_left, first_hit;
    logic [IW-1:0]       hit_pos;

    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_assigned_id, n_assigned_id;
    logic [POS_W-1:0]    r_position, n_position;
    logic [NUM_W-1:0]    r_number, n_number;

    logic                full, found;

    assign full     = (r_count == CW'(CAPACITY));
    assign found    = r_pre[CAPACITY-1];
    assign o_stat.is_remove = (r_action == ACT_REMOVE);

    assign o_status      = r_status;
    assign o_assigned_id = r_assigned_id;
    assign o_position    = r_position;
    assign o_number      = r_number;

    // per-entry compares
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_ge[i]    = (CW'(i) < r_count) && (r_ent_prio[i] >= r_prio);
            n_match[i] = (CW'(i) < r_count) && (r_ent_id[i] == r_target);
        end
    end

    // prefix or of the match vector, log2 levels
    always_comb begin
        n_pre = r_match;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            n_pre = n_pre | (n_pre << s);
        end
    end

    always_comb begin
        first_hit = r_pre & ~(r_pre << 1);
        hit_pos   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_pos = hit_pos | (first_hit[i] ? IW'(i) : IW'(0));
        end
    end

    assign ge_left = {r_ge[CAPACITY-2:0], 1'b1};

    // shift cells and result
    always_comb begin
        n_ent_prio    = r_ent_prio;
        n_ent_id      = r_ent_id;
        n_ent_tag     = r_ent_tag;
        n_count       = r_count;
        n_next_id     = r_next_id;
        n_status      = ST_OK;
        n_assigned_id = '0;
        n_position    = '0;
        n_number      = NUM_W'(r_count);
        case (r_action)
            ACT_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!r_ge[i]) begin
                            if (ge_left[i]) begin
                                n_ent_prio[i] = r_prio;
                                n_ent_id[i]   = r_next_id + 1'b1;
                                n_ent_tag[i]  = r_tag;
                            end else begin
                                n_ent_prio[i] = r_ent_prio[(i + CAPACITY - 1) % CAPACITY];
                                n_ent_id[i]   = r_ent_id[(i + CAPACITY - 1) % CAPACITY];
                                n_ent_tag[i]  = r_ent_tag[(i + CAPACITY - 1) % CAPACITY];
                            end
                        end
                    end
                    n_next_id     = r_next_id + 1'b1;
                    n_count       = r_count + 1'b1;
                    n_assigned_id = r_next_id + 1'b1;
                    n_number      = NUM_W'(r_count + 1'b1);
                end
            end
            ACT_REMOVE: begin
                if (found) begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (r_pre[i]) begin
                            n_ent_prio[i] = r_ent_prio[i + 1];
                            n_ent_id[i]   = r_ent_id[i + 1];
                            n_ent_tag[i]  = r_ent_tag[i + 1];
                        end
                    end
                    n_count    = r_count - 1'b1;
                    n_position = POS_W'(hit_pos);
                    n_number   = NUM_W'(r_count - 1'b1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            ACT_RESET_ID: begin
                n_next_id = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_next_id <= '0;
        end else if (i_cmd.apply) begin
            r_count   <= n_count;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_prio   <= i_prio;
            r_tag    <= i_handler_tag;
            r_target <= i_target_id;
        end
        if (i_cmd.look) begin
            r_ge    <= n_ge;
            r_match <= n_match;
        end
        if (i_cmd.scan) begin
            r_pre <= n_pre;
        end
        if (i_cmd.apply) begin
            r_ent_prio    <= n_ent_prio;
            r_ent_id      <= n_ent_id;
            r_ent_tag     <= n_ent_tag;
            r_status      <= n_status;
            r_assigned_id <= n_assigned_id;
            r_position    <= n_position;
            r_number      <= n_number;
        end
    end
endmodule

[hdl/stable_priority_event_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_event_queue
// Holds up to CAPACITY events sorted by descending priority, oldest first
// among equal priorities, in a row of entry registers that all compare and
// shift in parallel. One request is handled at a time. Insert, count, clear
// and id-counter reset go through load on acceptance, compare over the row
// and update. Remove by id adds the log-depth prefix scan that finds the
// first matching entry, between compare and update. The request side is
// ready again the cycle after the update. A result register lets the next
// request be accepted while the last result waits to be taken. That
// request's update then waits until the result is taken.
// ----------------------------------------------------------------------------
module stable_priority_event_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);
    import spq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    logic  req_fire;
    logic  rsp_full;
    logic  rsp_err;
    logic  rsp_extra;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    spq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_req.action),
        .i_prio        (i_req.prio),
        .i_handler_tag (i_req.handler_tag),
        .i_target_id   (i_req.target_id),
        .o_status      (o_rsp.status),
        .o_assigned_id (o_rsp.assigned_id),
        .o_position    (o_rsp.position),
        .o_number      (o_rsp.number)
    );

    assign req_fire  = i_req.valid && i_req.ready;
    assign rsp_full  = o_rsp.valid && (o_rsp.status == ST_FULL);
    assign rsp_err   = o_rsp.valid && (o_rsp.status != ST_OK);
    assign rsp_extra = (o_rsp.assigned_id != '0) || (o_rsp.position != '0);

`include "stable_priority_event_queue_assert.svh"

    `SPQ_ASSERT_NXT(a_busy_after_accept, req_fire, !i_req.ready, "ready after accept")
    `SPQ_ASSERT_NXT(a_apply_gives_rsp, cmd.apply, o_rsp.valid, "no response after update")
    `SPQ_ASSERT_IMP(a_full_count, rsp_full, o_rsp.number == NUM_W'(CAPACITY), "full below capacity")
    `SPQ_ASSERT_IMP(a_err_zero_fields, rsp_err, !rsp_extra, "error with id or position")
endmodule
